>>> rtl/ansi_sgr_color_tracker_core_defines.svh
// Assertion macros shared by the tracker RTL.
`ifndef ANSI_SGR_COLOR_TRACKER_CORE_DEFINES_SVH
`define ANSI_SGR_COLOR_TRACKER_CORE_DEFINES_SVH

// Checks a same-cycle implication on every clock edge outside reset.
`define ASCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks an implication in the next cycle.
`define ASCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/asct_pkg.sv
package asct_pkg;

  // Character codes recognized by the parser.
  localparam logic [7:0] ESC_BYTE      = 8'h1B;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_SEMI     = 8'h3B;
  localparam logic [7:0] CHAR_M        = 8'h6D;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;

  // SGR parameter codes.
  localparam logic [7:0] SGR_RESET    = 8'd0;
  localparam logic [7:0] SGR_BOLD     = 8'd1;
  localparam logic [7:0] SGR_FG_LO    = 8'd30;
  localparam logic [7:0] SGR_FG_HI    = 8'd37;
  localparam logic [7:0] SGR_BG_LO    = 8'd40;
  localparam logic [7:0] SGR_BG_HI    = 8'd47;
  localparam logic [7:0] SGR_FGB_LO   = 8'd90;
  localparam logic [7:0] SGR_FGB_HI   = 8'd97;
  localparam logic [7:0] SGR_BGB_LO   = 8'd100;
  localparam logic [7:0] SGR_BGB_HI   = 8'd107;
  localparam logic [7:0] PARAM_MAX    = 8'd255;

  // Default attributes.
  localparam logic [3:0] FG_DEFAULT = 4'd7;
  localparam logic [3:0] BG_DEFAULT = 4'd0;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_ESC   = 3'b010,
    PH_SEQ   = 3'b100
  } phase_t;

  // State of the parameter being gathered.
  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_DIGITS = 2'd1,
    ST_BAD    = 2'd2
  } pstat_t;

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
    logic       bold;
  } attr_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       visible;
    logic [3:0] fg_index;
    logic [3:0] bg_index;
    logic       bold_on;
    logic       last_of_run;
  } result_t;

  // Push request from the parser into the result queue.
  typedef struct packed {
    logic valid;
    logic two;
  } push_t;

endpackage

>>> rtl/asct_ifs.sv
// Input channel: one text byte or clear command per beat.
interface asct_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] text_byte;
  modport source (output valid, command, text_byte, input ready);
  modport sink (input valid, command, text_byte, output ready);
endinterface

// Result channel: one tagged character per beat.
interface asct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       visible;
  logic [3:0] fg_index;
  logic [3:0] bg_index;
  logic       bold_on;
  logic       last_of_run;
  modport source (output valid, char_out, visible, fg_index, bg_index, bold_on,
                  last_of_run, input ready);
  modport sink (input valid, char_out, visible, fg_index, bg_index, bold_on,
                last_of_run, output ready);
endinterface

>>> rtl/asct_parser.sv
module asct_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [7:0]          in_text_byte,
  input  logic [1:0]          q_space,
  output asct_pkg::push_t     push,
  output asct_pkg::result_t   res0,
  output asct_pkg::result_t   res1
);

  // Applies one complete parameter to the attributes.
  function automatic asct_pkg::attr_t apply_param(asct_pkg::attr_t a, logic [7:0] c);
    asct_pkg::attr_t r;
    logic [7:0]      off;
    r = a;
    off = 8'd0;
    if (c == asct_pkg::SGR_RESET) begin
      r.fg = asct_pkg::FG_DEFAULT;
      r.bg = asct_pkg::BG_DEFAULT;
      r.bold = 1'b0;
    end else if (c == asct_pkg::SGR_BOLD) begin
      r.bold = 1'b1;
      r.fg = a.fg | 4'd8;
    end else if (c >= asct_pkg::SGR_FG_LO && c <= asct_pkg::SGR_FG_HI) begin
      off = c - asct_pkg::SGR_FG_LO;
      r.fg = {a.bold, off[2:0]};
    end else if (c >= asct_pkg::SGR_BG_LO && c <= asct_pkg::SGR_BG_HI) begin
      off = c - asct_pkg::SGR_BG_LO;
      r.bg = {1'b0, off[2:0]};
    end else if (c >= asct_pkg::SGR_FGB_LO && c <= asct_pkg::SGR_FGB_HI) begin
      off = c - asct_pkg::SGR_FGB_LO;
      r.fg = {1'b1, off[2:0]};
    end else if (c >= asct_pkg::SGR_BGB_LO && c <= asct_pkg::SGR_BGB_HI) begin
      off = c - asct_pkg::SGR_BGB_LO;
      r.bg = {1'b1, off[2:0]};
    end
    return r;
  endfunction

  logic                 in_v_r;
  logic                 cmd_r;
  logic [7:0]           byte_r;
  asct_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]           val_r, val_nxt;
  asct_pkg::pstat_t     stat_r, stat_nxt;
  asct_pkg::attr_t      attr_r, attr_nxt;
  logic                 two;
  logic                 fire;
  logic                 vis;
  logic [3:0]           digit;
  logic [11:0]          acc;
  asct_pkg::attr_t      applied;

  // Input register accepts a new beat whenever the held one moves on.
  assign fire     = in_v_r && (two ? (q_space == 2'd2) : (q_space != 2'd0));
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r  <= in_command;
      byte_r <= in_text_byte;
    end
  end

  // Digit accumulation: value * 10 + digit, wide enough to see overflow.
  assign digit   = 4'(byte_r - asct_pkg::CHAR_ZERO);
  assign acc     = {1'b0, val_r, 3'b000} + {3'b000, val_r, 1'b0} + {8'd0, digit};
  assign applied = (stat_r == asct_pkg::ST_DIGITS) ? apply_param(attr_r, val_r) : attr_r;

  // Next state and results for the held beat.
  always_comb begin
    phase_nxt = phase_r;
    val_nxt   = val_r;
    stat_nxt  = stat_r;
    attr_nxt  = attr_r;
    two       = 1'b0;
    vis       = 1'b0;
    if (cmd_r) begin
      attr_nxt  = '{fg: asct_pkg::FG_DEFAULT, bg: asct_pkg::BG_DEFAULT, bold: 1'b0};
      phase_nxt = asct_pkg::PH_PLAIN;
      val_nxt   = 8'd0;
      stat_nxt  = asct_pkg::ST_EMPTY;
    end else begin
      case (phase_r)
        asct_pkg::PH_ESC: begin
          if (byte_r == asct_pkg::CHAR_LBRACKET) begin
            phase_nxt = asct_pkg::PH_SEQ;
            val_nxt   = 8'd0;
            stat_nxt  = asct_pkg::ST_EMPTY;
          end else begin
            two = 1'b1;
            vis = (byte_r != asct_pkg::ESC_BYTE);
            phase_nxt = vis ? asct_pkg::PH_PLAIN : asct_pkg::PH_ESC;
          end
        end
        asct_pkg::PH_SEQ: begin
          if (byte_r == asct_pkg::CHAR_M || byte_r == asct_pkg::CHAR_SEMI) begin
            attr_nxt = applied;
            val_nxt  = 8'd0;
            stat_nxt = asct_pkg::ST_EMPTY;
            if (byte_r == asct_pkg::CHAR_M) begin
              phase_nxt = asct_pkg::PH_PLAIN;
            end
          end else if (byte_r >= asct_pkg::CHAR_ZERO && byte_r <= asct_pkg::CHAR_NINE) begin
            if (stat_r != asct_pkg::ST_BAD) begin
              if (acc > {4'd0, asct_pkg::PARAM_MAX}) begin
                val_nxt  = asct_pkg::PARAM_MAX;
                stat_nxt = asct_pkg::ST_BAD;
              end else begin
                val_nxt  = acc[7:0];
                stat_nxt = asct_pkg::ST_DIGITS;
              end
            end
          end else begin
            stat_nxt = asct_pkg::ST_BAD;
          end
        end
        default: begin
          vis = (byte_r != asct_pkg::ESC_BYTE);
          phase_nxt = vis ? asct_pkg::PH_PLAIN : asct_pkg::PH_ESC;
        end
      endcase
    end
  end

  // Result beats. The second is only used for a literal ESC.
  always_comb begin
    res0.visible     = vis || two;
    res0.char_out    = two ? asct_pkg::ESC_BYTE : (vis ? byte_r : 8'd0);
    res0.fg_index    = attr_nxt.fg;
    res0.bg_index    = attr_nxt.bg;
    res0.bold_on     = attr_nxt.bold;
    res0.last_of_run = !two;
    res1.visible     = vis;
    res1.char_out    = vis ? byte_r : 8'd0;
    res1.fg_index    = attr_nxt.fg;
    res1.bg_index    = attr_nxt.bg;
    res1.bold_on     = attr_nxt.bold;
    res1.last_of_run = 1'b1;
  end

  assign push.valid = fire;
  assign push.two   = two;

  // Parser state advances once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= asct_pkg::PH_PLAIN;
      val_r   <= 8'd0;
      stat_r  <= asct_pkg::ST_EMPTY;
      attr_r  <= '{fg: asct_pkg::FG_DEFAULT, bg: asct_pkg::BG_DEFAULT, bold: 1'b0};
    end else if (fire) begin
      phase_r <= phase_nxt;
      val_r   <= val_nxt;
      stat_r  <= stat_nxt;
      attr_r  <= attr_nxt;
    end
  end

endmodule

>>> rtl/asct_out_q.sv
module asct_out_q (
  input  logic                clk,
  input  logic                rst_n,
  input  asct_pkg::push_t     push,
  input  asct_pkg::result_t   res0,
  input  asct_pkg::result_t   res1,
  output logic [1:0]          q_space,
  output logic                out_valid,
  input  logic                out_ready,
  output asct_pkg::result_t   out_res
);

  asct_pkg::result_t ent_r [2];
  asct_pkg::result_t ent0_nxt, ent1_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [1:0]        base;
  logic              pop;

  // Head entry drives the result channel.
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = ent_r[0];
  assign pop       = out_valid && out_ready;
  assign base      = cnt_r - {1'b0, pop};
  assign q_space   = 2'd2 - base;

  // Shift on pop, then append the pushed beats behind what remains.
  always_comb begin
    ent0_nxt = pop ? ent_r[1] : ent_r[0];
    ent1_nxt = ent_r[1];
    cnt_nxt  = base;
    if (push.valid) begin
      if (base == 2'd0) begin
        ent0_nxt = res0;
        ent1_nxt = res1;
      end else begin
        ent1_nxt = res0;
      end
      cnt_nxt = base + (push.two ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r[0] <= ent0_nxt;
    ent_r[1] <= ent1_nxt;
  end

endmodule

>>> rtl/ansi_sgr_color_tracker_core.sv
// A beat is held in the parser's input register and its result beats go into the result queue,
// which drives the result channel. Throughput: one input beat per cycle while the queue has
// room; a literal ESC gives two result beats and its push waits for an empty two-entry queue.
// Reset (rst_n low, synchronous) returns the parser to plain text, the attributes
// to foreground 7, background 0, bold off, and empties the input and result registers.
`include "ansi_sgr_color_tracker_core_defines.svh"

module ansi_sgr_color_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  asct_in_if.sink     in_chan,
  asct_out_if.source  out_chan
);

  asct_pkg::push_t   push;
  asct_pkg::result_t res0, res1, out_res;
  logic [1:0]        q_space;

  // Byte parser with its input register and attribute state.
  asct_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_command   (in_chan.command),
    .in_text_byte (in_chan.text_byte),
    .q_space      (q_space),
    .push         (push),
    .res0         (res0),
    .res1         (res1)
  );

  // Result queue that also serves as the output register.
  asct_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .q_space   (q_space),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.char_out    = out_res.char_out;
  assign out_chan.visible     = out_res.visible;
  assign out_chan.fg_index    = out_res.fg_index;
  assign out_chan.bg_index    = out_res.bg_index;
  assign out_chan.bold_on     = out_res.bold_on;
  assign out_chan.last_of_run = out_res.last_of_run;

  // A two-beat push only happens into an empty queue.
  `ASCT_ASSERT_IMP(a_two_fits, push.valid && push.two, q_space == 2'd2,
                   "two-beat push overflows queue")
  // An empty result channel means the queue has full room.
  `ASCT_ASSERT_IMP(a_empty_space, !out_chan.valid, q_space == 2'd2, "queue space lost while empty")
  // A beat that is not the last of its run is always the literal ESC.
  `ASCT_ASSERT_IMP(a_first_is_esc, out_chan.valid && !out_chan.last_of_run,
                   out_chan.visible && out_chan.char_out == asct_pkg::ESC_BYTE,
                   "non-final beat is not a literal ESC")
  // A literal ESC beat is followed by the rest of its run.
  `ASCT_ASSERT_NXT(a_esc_followed, out_chan.valid && !out_chan.last_of_run, out_chan.valid,
                   "second beat of a literal ESC run missing")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS     = 1750;
  localparam int DRAIN_SPACING    = 400;
  localparam int LONG_HOLD_AT     = 900;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int IDLE_LIMIT       = 5000;
  localparam int TAIL_CYCLES      = 10;

  // One pending input beat; drain_first makes the sender wait for all results first.
  typedef struct {
    logic       command;
    logic [7:0] text_byte;
    bit         drain_first;
  } stream_item_t;

  logic clk;
  logic rst_n;

  asct_in_if  in_bus ();
  asct_out_if out_bus ();

  ansi_sgr_color_tracker_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  stream_item_t      byte_stream[$];
  asct_pkg::result_t expected_cells[$];
  bit                drain_next;

  // Tracker state mirrored by the bench.
  asct_pkg::phase_t trk_phase;
  logic [7:0]       trk_param;
  asct_pkg::pstat_t trk_pstat;
  asct_pkg::attr_t  trk_attr;

  int expected_total;
  int beats_seen;
  int in_beats;
  int errors;
  int n_seq;
  int n_lit;
  int n_clear;

  // Sender burst and gap counters.
  int burst_left;
  int gap_left;

  // Receiver stall pattern.
  int unsigned rx_phase;
  int          rx_mode;
  int          hold_left;
  bit          long_hold_done;

  asct_pkg::result_t mon_got;
  asct_pkg::result_t mon_want;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stimulus construction helpers.
  function automatic void queue_byte(logic cmd, logic [7:0] b);
    stream_item_t item;
    item.command     = cmd;
    item.text_byte   = b;
    item.drain_first = drain_next;
    drain_next       = 1'b0;
    byte_stream      = {byte_stream, item};
  endfunction

  function automatic void queue_number(int unsigned n, bit may_pad);
    int unsigned div;
    logic [7:0]  digit;
    div = 1;
    while (div * 10 <= n) div = div * 10;
    // A leading zero leaves the value unchanged.
    if (may_pad && $urandom_range(0, 9) == 0) queue_byte(1'b0, asct_pkg::CHAR_ZERO);
    while (div != 0) begin
      digit = 8'((n / div) % 10);
      queue_byte(1'b0, asct_pkg::CHAR_ZERO + digit);
      div = div / 10;
    end
  endfunction

  // One SGR parameter of a random kind, good or bad.
  function automatic void queue_sgr_param();
    int         pick;
    logic [7:0] junk;
    pick = $urandom_range(0, 12);
    if (pick == 0) queue_number(32'(asct_pkg::SGR_RESET), 1'b1);
    else if (pick <= 2) queue_number(32'(asct_pkg::SGR_BOLD), 1'b1);
    else if (pick <= 4)
      queue_number($urandom_range(32'(asct_pkg::SGR_FG_LO), 32'(asct_pkg::SGR_FG_HI)), 1'b1);
    else if (pick == 5)
      queue_number($urandom_range(32'(asct_pkg::SGR_BG_LO), 32'(asct_pkg::SGR_BG_HI)), 1'b1);
    else if (pick == 6)
      queue_number($urandom_range(32'(asct_pkg::SGR_FGB_LO), 32'(asct_pkg::SGR_FGB_HI)),
                   1'b1);
    else if (pick == 7)
      queue_number($urandom_range(32'(asct_pkg::SGR_BGB_LO), 32'(asct_pkg::SGR_BGB_HI)),
                   1'b1);
    else if (pick == 8) queue_number($urandom_range(0, 255), 1'b1);
    else if (pick == 9) queue_number($urandom_range(256, 99999), 1'b0);
    else if (pick == 10) begin
      // Empty parameter: nothing between separators.
    end else begin
      // A non-digit byte spoils the parameter, wherever it falls.
      if ($urandom_range(0, 1) == 1) queue_number($urandom_range(0, 107), 1'b0);
      junk = 8'($urandom_range(0, 255));
      if ((junk >= asct_pkg::CHAR_ZERO && junk <= asct_pkg::CHAR_NINE) ||
          junk == asct_pkg::CHAR_SEMI || junk == asct_pkg::CHAR_M)
        junk = asct_pkg::ESC_BYTE;
      queue_byte(1'b0, junk);
      if ($urandom_range(0, 1) == 1) queue_number($urandom_range(30, 47), 1'b0);
    end
  endfunction

  function automatic void queue_sgr_sequence();
    int nparams;
    nparams = $urandom_range(1, 4);
    queue_byte(1'b0, asct_pkg::ESC_BYTE);
    queue_byte(1'b0, asct_pkg::CHAR_LBRACKET);
    for (int i = 0; i < nparams; i++) begin
      if (i != 0) queue_byte(1'b0, asct_pkg::CHAR_SEMI);
      queue_sgr_param();
    end
    queue_byte(1'b0, asct_pkg::CHAR_M);
  endfunction

  // Attribute tracking, beat by beat.
  function automatic void set_defaults();
    trk_attr.fg   = asct_pkg::FG_DEFAULT;
    trk_attr.bg   = asct_pkg::BG_DEFAULT;
    trk_attr.bold = 1'b0;
  endfunction

  function automatic void clear_param();
    trk_param = 8'd0;
    trk_pstat = asct_pkg::ST_EMPTY;
  endfunction

  function automatic void apply_param();
    logic [7:0] offs;
    if (trk_pstat == asct_pkg::ST_DIGITS) begin
      if (trk_param == asct_pkg::SGR_RESET) begin
        set_defaults();
      end else if (trk_param == asct_pkg::SGR_BOLD) begin
        trk_attr.bold = 1'b1;
        trk_attr.fg   = trk_attr.fg | 4'd8;
      end else if (trk_param >= asct_pkg::SGR_FG_LO && trk_param <= asct_pkg::SGR_FG_HI) begin
        offs = trk_param - asct_pkg::SGR_FG_LO;
        trk_attr.fg = {trk_attr.bold, offs[2:0]};
      end else if (trk_param >= asct_pkg::SGR_BG_LO && trk_param <= asct_pkg::SGR_BG_HI) begin
        offs = trk_param - asct_pkg::SGR_BG_LO;
        trk_attr.bg = {1'b0, offs[2:0]};
      end else if (trk_param >= asct_pkg::SGR_FGB_LO &&
                   trk_param <= asct_pkg::SGR_FGB_HI) begin
        offs = trk_param - asct_pkg::SGR_FGB_LO;
        trk_attr.fg = {1'b1, offs[2:0]};
      end else if (trk_param >= asct_pkg::SGR_BGB_LO &&
                   trk_param <= asct_pkg::SGR_BGB_HI) begin
        offs = trk_param - asct_pkg::SGR_BGB_LO;
        trk_attr.bg = {1'b1, offs[2:0]};
      end
    end
  endfunction

  function automatic void push_cell(logic [7:0] ch, logic vis, logic last);
    asct_pkg::result_t exp_beat;
    exp_beat.char_out    = vis ? ch : 8'h00;
    exp_beat.visible     = vis;
    exp_beat.fg_index    = trk_attr.fg;
    exp_beat.bg_index    = trk_attr.bg;
    exp_beat.bold_on     = trk_attr.bold;
    exp_beat.last_of_run = last;
    expected_cells = {expected_cells, exp_beat};
    expected_total++;
  endfunction

  // A plain-text byte is shown unless it is ESC, which opens an escape.
  function automatic logic plain_byte(logic [7:0] b);
    if (b == asct_pkg::ESC_BYTE) begin
      trk_phase = asct_pkg::PH_ESC;
      return 1'b0;
    end
    trk_phase = asct_pkg::PH_PLAIN;
    return 1'b1;
  endfunction

  function automatic void track_input(logic cmd, logic [7:0] b);
    logic        vis;
    int unsigned acc;
    if (cmd) begin
      set_defaults();
      trk_phase = asct_pkg::PH_PLAIN;
      clear_param();
      push_cell(8'h00, 1'b0, 1'b1);
    end else if (trk_phase == asct_pkg::PH_ESC) begin
      if (b == asct_pkg::CHAR_LBRACKET) begin
        trk_phase = asct_pkg::PH_SEQ;
        clear_param();
        push_cell(8'h00, 1'b0, 1'b1);
      end else begin
        // Lone ESC comes out as a literal, then the byte is taken as text.
        push_cell(asct_pkg::ESC_BYTE, 1'b1, 1'b0);
        vis = plain_byte(b);
        push_cell(b, vis, 1'b1);
      end
    end else if (trk_phase == asct_pkg::PH_SEQ) begin
      if (b == asct_pkg::CHAR_M) begin
        apply_param();
        clear_param();
        trk_phase = asct_pkg::PH_PLAIN;
      end else if (b == asct_pkg::CHAR_SEMI) begin
        apply_param();
        clear_param();
      end else if (b >= asct_pkg::CHAR_ZERO && b <= asct_pkg::CHAR_NINE) begin
        if (trk_pstat != asct_pkg::ST_BAD) begin
          acc = 32'(trk_param) * 10 + 32'(b - asct_pkg::CHAR_ZERO);
          if (acc > 32'(asct_pkg::PARAM_MAX)) begin
            trk_param = asct_pkg::PARAM_MAX;
            trk_pstat = asct_pkg::ST_BAD;
          end else begin
            trk_param = 8'(acc);
            trk_pstat = asct_pkg::ST_DIGITS;
          end
        end
      end else begin
        trk_pstat = asct_pkg::ST_BAD;
      end
      push_cell(8'h00, 1'b0, 1'b1);
    end else begin
      vis = plain_byte(b);
      push_cell(b, vis, 1'b1);
    end
  endfunction

  function automatic string fmt_cell(asct_pkg::result_t c);
    return $sformatf("char=%h vis=%b fg=%0d bg=%0d bold=%b last=%b",
                     c.char_out, c.visible, c.fg_index, c.bg_index, c.bold_on,
                     c.last_of_run);
  endfunction

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= 10) $display("tb: %s", msg);
  endfunction

  // Sender: presents the head of the stream in bursts with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        track_input(in_bus.command, in_bus.text_byte);
        void'(byte_stream.pop_front());
        in_beats <= in_beats + 1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                   : $urandom_range(0, 3);
        end
      end
      if (gap_left != 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (byte_stream.size() == 0 ||
                   (byte_stream[0].drain_first && beats_seen != expected_total)) begin
        in_bus.valid <= 1'b0;
      end else begin
        in_bus.valid     <= 1'b1;
        in_bus.command   <= byte_stream[0].command;
        in_bus.text_byte <= byte_stream[0].text_byte;
      end
    end
  end

  // Receiver: switches among random stall patterns, with one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (!long_hold_done && in_beats >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      rx_phase++;
      if (rx_phase % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        2: out_bus.ready <= ($urandom_range(0, 2) == 0);
        default: out_bus.ready <= (rx_phase % 4 != 0);
      endcase
    end
  end

  // Monitor: every result beat is checked against the oldest expected beat.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      mon_got.char_out    = out_bus.char_out;
      mon_got.visible     = out_bus.visible;
      mon_got.fg_index    = out_bus.fg_index;
      mon_got.bg_index    = out_bus.bg_index;
      mon_got.bold_on     = out_bus.bold_on;
      mon_got.last_of_run = out_bus.last_of_run;
      if (expected_cells.size() == 0) begin
        note_failure($sformatf("unexpected result beat %0d: %s", beats_seen,
                               fmt_cell(mon_got)));
      end else begin
        mon_want = expected_cells.pop_front();
        if (mon_got !== mon_want)
          note_failure($sformatf("result beat %0d: expected %s, got %s", beats_seen,
                                 fmt_cell(mon_want), fmt_cell(mon_got)));
      end
      beats_seen <= beats_seen + 1;
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: no beat moved for %0d cycles, %0d results outstanding", idle_cycles,
             expected_cells.size());
    $display("tb: done, errors");
    $finish;
  end

  initial begin : main
    int         pick;
    int         next_drain;
    int         nbytes;
    int         target;
    logic [7:0] b;

    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.command   = 1'b0;
    in_bus.text_byte = 8'h00;
    out_bus.ready    = 1'b0;
    set_defaults();
    trk_phase = asct_pkg::PH_PLAIN;
    clear_param();

    // Directed part: byte extremes, bold then normal red, a literal ESC
    // followed by an ESC that opens a sequence, an empty and an overflowed
    // parameter, and a clear command.
    queue_byte(1'b0, 8'h00);
    queue_byte(1'b0, 8'hFF);
    queue_byte(1'b0, asct_pkg::ESC_BYTE);
    queue_byte(1'b0, asct_pkg::CHAR_LBRACKET);
    queue_number(32'(asct_pkg::SGR_BOLD), 1'b0);
    queue_byte(1'b0, asct_pkg::CHAR_SEMI);
    queue_number(31, 1'b0);
    queue_byte(1'b0, asct_pkg::CHAR_M);
    queue_byte(1'b0, asct_pkg::ESC_BYTE);
    queue_byte(1'b0, asct_pkg::ESC_BYTE);
    queue_byte(1'b0, asct_pkg::CHAR_LBRACKET);
    queue_number(32'(asct_pkg::SGR_BGB_HI), 1'b0);
    queue_byte(1'b0, asct_pkg::CHAR_M);
    queue_byte(1'b0, asct_pkg::ESC_BYTE);
    queue_byte(1'b0, asct_pkg::CHAR_LBRACKET);
    queue_byte(1'b0, asct_pkg::CHAR_SEMI);
    queue_number(256, 1'b0);
    queue_byte(1'b0, asct_pkg::CHAR_SEMI);
    queue_number(32'(asct_pkg::SGR_FGB_HI), 1'b0);
    queue_byte(1'b0, asct_pkg::CHAR_M);
    queue_byte(1'b1, 8'hFF);

    // Random part: mostly well-formed sequences, the rest text and noise.
    target     = byte_stream.size() + RANDOM_ITEMS;
    next_drain = byte_stream.size();
    while (byte_stream.size() < target) begin
      if (byte_stream.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain = next_drain + DRAIN_SPACING;
      end
      pick = $urandom_range(0, 19);
      if (pick <= 10) begin
        queue_sgr_sequence();
        n_seq++;
      end else if (pick <= 13) begin
        nbytes = $urandom_range(1, 8);
        repeat (nbytes) queue_byte(1'b0, 8'($urandom_range(0, 255)));
      end else if (pick <= 15) begin
        // ESC not followed by a bracket; a second ESC opens a new escape.
        b = 8'($urandom_range(0, 255));
        if (b == asct_pkg::CHAR_LBRACKET) b = asct_pkg::ESC_BYTE;
        queue_byte(1'b0, asct_pkg::ESC_BYTE);
        queue_byte(1'b0, b);
        n_lit++;
      end else if (pick == 16) begin
        queue_byte(1'b1, 8'($urandom_range(0, 255)));
        n_clear++;
      end else if (pick <= 18) begin
        // Broken sequence: random body, ended by 'm', a clear, or left open.
        queue_byte(1'b0, asct_pkg::ESC_BYTE);
        queue_byte(1'b0, asct_pkg::CHAR_LBRACKET);
        nbytes = $urandom_range(1, 6);
        repeat (nbytes) queue_byte(1'b0, 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 2))
          0: queue_byte(1'b0, asct_pkg::CHAR_M);
          1: begin
            queue_byte(1'b1, 8'($urandom_range(0, 255)));
            n_clear++;
          end
          default: ;
        endcase
      end else begin
        // Clear arriving right after an ESC.
        queue_byte(1'b0, asct_pkg::ESC_BYTE);
        queue_byte(1'b1, 8'($urandom_range(0, 255)));
        n_clear++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to go in and every result to come back.
    while (byte_stream.size() != 0 || beats_seen != expected_total) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d input beats (%0d SGR sequences, %0d ESC literals, %0d clears)",
             in_beats, n_seq, n_lit, n_clear);
    $display("tb: %0d result beats checked under bursty input and stalled output, %0d errors",
             beats_seen, errors);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/asct_pkg.sv
rtl/asct_ifs.sv
rtl/asct_parser.sv
rtl/asct_out_q.sv
rtl/ansi_sgr_color_tracker_core.sv
bench/tb.sv
